// ===== rtl/core/irt_pkg.sv =====
// Shared types, constants and helpers for the IP route table.
package irt_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DEL    = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // 127.0.0.0/8 as a little-endian word of a network-order address
  localparam logic [31:0] LOOPBACK_NET  = 32'h0000_007f;
  localparam logic [31:0] LOOPBACK_MASK = 32'h0000_00ff;
  localparam logic [31:0] DEFAULT_COST  = 32'h0000_0001;

  // Most result beats one dump may produce
  localparam int unsigned MAX_BEATS = 16;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [3:0]  iface;
    logic [31:0] cost;
  } entry_t;

  typedef struct packed {
    logic        status;
    logic [31:0] hop_addr;
    logic [3:0]  out_iface;
    logic [31:0] entry_dest;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [31:0] entry_cost;
    logic        entry_valid;
    logic [4:0]  dumped_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic scan_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_push;
    logic out_free;
  } sts_t;

  // Contents a slot holds from reset until its first write
  function automatic entry_t reset_entry(logic is_slot0, logic is_slot1);
    entry_t e;
    e = '0;
    if (is_slot0) begin
      e.dest = LOOPBACK_NET;
      e.mask = LOOPBACK_MASK;
    end
    if (is_slot1) begin
      e.cost = DEFAULT_COST;
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/irt_if.sv =====
// Request and response channel interfaces of the IP route table.
interface irt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        dest_addr;
  logic [31:0]        prefix_mask;
  logic [31:0]        gateway_addr;
  logic [3:0]         iface_num;
  logic               iface_given;
  logic signed [31:0] route_cost;
  logic [4:0]         dump_limit;

  modport source (
    output valid, mode, dest_addr, prefix_mask, gateway_addr, iface_num, iface_given,
           route_cost, dump_limit,
    input  ready
  );
  modport sink (
    input  valid, mode, dest_addr, prefix_mask, gateway_addr, iface_num, iface_given,
           route_cost, dump_limit,
    output ready
  );
endinterface

interface irt_rsp_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [31:0]        hop_addr;
  logic [3:0]         out_iface;
  logic [31:0]        entry_dest;
  logic [31:0]        entry_mask;
  logic [31:0]        entry_gateway;
  logic signed [31:0] entry_cost;
  logic               entry_valid;
  logic [4:0]         dumped_count;
  logic               last;

  modport source (
    output valid, status, hop_addr, out_iface, entry_dest, entry_mask, entry_gateway,
           entry_cost, entry_valid, dumped_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, hop_addr, out_iface, entry_dest, entry_mask, entry_gateway,
           entry_cost, entry_valid, dumped_count, last,
    output ready
  );
endinterface

// ===== rtl/core/irt_ctrl.sv =====
// Sequencer: accepts a request, walks the slot scan, then commits and answers.
module irt_ctrl #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  irt_pkg::sts_t                sts_i,
  output irt_pkg::cmd_t                cmd_o,
  output logic [$clog2(ENTRIES)-1:0]   rd_idx_o,
  output logic [$clog2(ENTRIES)-1:0]   chk_idx_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic            chk_vld_q;
  logic [IW-1:0]   chk_idx_q;

  logic issuing;
  logic stall;

  always_comb begin
    issuing       = cnt_q < CW'(ENTRIES);
    stall         = chk_vld_q & sts_i.need_push & ~sts_i.out_free;
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.load    = in_ready_o & in_valid_i;
    cmd_o.rd_en   = (state_q == ST_SCAN) & issuing & ~stall;
    cmd_o.scan_en = (state_q == ST_SCAN) & chk_vld_q & ~stall;
    cmd_o.finish  = (state_q == ST_FINISH) & sts_i.out_free;
    rd_idx_o      = cnt_q[IW-1:0];
    chk_idx_o     = chk_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q   <= ST_SCAN;
            cnt_q     <= '0;
            chk_vld_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          // hold both stages while a dump beat waits for the output register
          if (!stall) begin
            chk_vld_q <= issuing;
            chk_idx_q <= cnt_q[IW-1:0];
            if (issuing) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/irt_dp.sv =====
// Datapath: slot memory, valid bits, scan comparators and the result register.
module irt_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   mode_i,
  input  logic [31:0]                  dest_addr_i,
  input  logic [31:0]                  prefix_mask_i,
  input  logic [31:0]                  gateway_addr_i,
  input  logic [3:0]                   iface_num_i,
  input  logic                         iface_given_i,
  input  logic [31:0]                  route_cost_i,
  input  logic [4:0]                   dump_limit_i,
  input  irt_pkg::cmd_t                cmd_i,
  input  logic [$clog2(ENTRIES)-1:0]   rd_idx_i,
  input  logic [$clog2(ENTRIES)-1:0]   chk_idx_i,
  output irt_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output irt_pkg::res_t                out_o
);

  localparam int unsigned IW      = $clog2(ENTRIES);
  localparam int unsigned LIM_CAP = (ENTRIES < irt_pkg::MAX_BEATS) ? ENTRIES
                                                                   : irt_pkg::MAX_BEATS;

  // Request held for the whole scan
  irt_pkg::mode_e  mode_q;
  logic [31:0]     dest_q;
  logic [31:0]     mask_q;
  logic [31:0]     gw_q;
  logic [3:0]      ifn_q;
  logic            ifgiven_q;
  logic [31:0]     cost_q;
  logic [4:0]      lim_q;

  // Slot storage
  irt_pkg::entry_t mem_q [ENTRIES];
  irt_pkg::entry_t rd_data_q;
  logic            rd_written_q;
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] written_q;

  // Scan accumulators
  logic            hit_q;
  logic [IW-1:0]   hit_idx_q;
  logic [3:0]      hit_iface_q;
  logic            free_q;
  logic [IW-1:0]   free_idx_q;
  logic [31:0]     best_mask_q;
  logic [31:0]     best_gw_q;
  logic            pend_q;
  irt_pkg::entry_t pend_entry_q;
  logic [4:0]      cnt_q;

  logic            out_vld_q;
  irt_pkg::res_t   out_q;

  irt_pkg::entry_t ent;
  logic            slot_v;
  logic            exact;
  logic            pfx;
  logic            take_dump;
  logic            need_push;
  logic            push;
  logic            hit_upd;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  irt_pkg::entry_t wr_entry;
  irt_pkg::res_t   res_fin;
  irt_pkg::res_t   res_push;

  always_comb begin
    ent = rd_written_q ? rd_data_q
                       : irt_pkg::reset_entry(chk_idx_i == '0, chk_idx_i == IW'(1));
    slot_v    = valid_q[chk_idx_i];
    exact     = slot_v & (ent.dest == dest_q) & (ent.mask == mask_q);
    pfx       = slot_v & ((dest_q & ent.mask) == (ent.dest & ent.mask));
    take_dump = (mode_q == irt_pkg::MODE_DUMP) & slot_v & (cnt_q < lim_q);
    need_push = take_dump & pend_q;
    push      = cmd_i.scan_en & need_push;

    unique case (mode_q)
      irt_pkg::MODE_ADD,
      irt_pkg::MODE_DEL:    hit_upd = exact & ~hit_q;
      irt_pkg::MODE_LOOKUP: hit_upd = pfx & (~hit_q | (ent.mask >= best_mask_q));
      irt_pkg::MODE_DUMP:   hit_upd = 1'b0;
      default:              hit_upd = 1'b0;
    endcase

    sts_o.need_push = need_push;
    sts_o.out_free  = ~out_vld_q | out_ready_i;

    wr_en          = cmd_i.finish & (mode_q == irt_pkg::MODE_ADD) & (hit_q | free_q);
    wr_idx         = hit_q ? hit_idx_q : free_idx_q;
    wr_entry.dest  = dest_q;
    wr_entry.mask  = mask_q;
    wr_entry.gw    = gw_q;
    wr_entry.iface = ifgiven_q ? ifn_q : (hit_q ? hit_iface_q : 4'd0);
    wr_entry.cost  = cost_q;

    res_push               = '0;
    res_push.status        = irt_pkg::STATUS_OK;
    res_push.out_iface     = pend_entry_q.iface;
    res_push.entry_dest    = pend_entry_q.dest;
    res_push.entry_mask    = pend_entry_q.mask;
    res_push.entry_gateway = pend_entry_q.gw;
    res_push.entry_cost    = pend_entry_q.cost;
    res_push.entry_valid   = 1'b1;
    res_push.dumped_count  = cnt_q;

    res_fin      = '0;
    res_fin.last = 1'b1;
    unique case (mode_q)
      irt_pkg::MODE_ADD: begin
        res_fin.status = (hit_q | free_q) ? irt_pkg::STATUS_OK : irt_pkg::STATUS_FAIL;
      end
      irt_pkg::MODE_DEL: begin
        res_fin.status = hit_q ? irt_pkg::STATUS_OK : irt_pkg::STATUS_FAIL;
      end
      irt_pkg::MODE_LOOKUP: begin
        res_fin.status = hit_q ? irt_pkg::STATUS_OK : irt_pkg::STATUS_FAIL;
        if (hit_q) begin
          res_fin.hop_addr  = (best_gw_q != 32'd0) ? best_gw_q : dest_q;
          res_fin.out_iface = hit_iface_q;
        end
      end
      irt_pkg::MODE_DUMP: begin
        // last entry found closes the dump; none found gives an empty beat
        if (pend_q) begin
          res_fin      = res_push;
          res_fin.last = 1'b1;
        end
      end
      default: res_fin.status = irt_pkg::STATUS_FAIL;
    endcase
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= irt_pkg::mode_e'(mode_i);
      dest_q    <= dest_addr_i;
      mask_q    <= prefix_mask_i;
      gw_q      <= gateway_addr_i;
      ifn_q     <= iface_num_i;
      ifgiven_q <= iface_given_i;
      cost_q    <= route_cost_i;
      lim_q     <= (dump_limit_i > 5'(LIM_CAP)) ? 5'(LIM_CAP) : dump_limit_i;
    end
  end

  // Slot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_entry;
    end
    if (cmd_i.rd_en) begin
      rd_data_q    <= mem_q[rd_idx_i];
      rd_written_q <= written_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= ENTRIES'(3);
      written_q <= '0;
    end else if (cmd_i.finish) begin
      if (wr_en) begin
        valid_q[wr_idx]   <= 1'b1;
        written_q[wr_idx] <= 1'b1;
      end
      if ((mode_q == irt_pkg::MODE_DEL) && hit_q) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  // Scan flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.scan_en) begin
      if (hit_upd) begin
        hit_q <= 1'b1;
      end
      if (!slot_v) begin
        free_q <= 1'b1;
      end
      if (take_dump) begin
        pend_q <= 1'b1;
        cnt_q  <= cnt_q + 5'd1;
      end
    end
  end

  // Scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if (hit_upd) begin
        hit_idx_q   <= chk_idx_i;
        hit_iface_q <= ent.iface;
        best_mask_q <= ent.mask;
        best_gw_q   <= ent.gw;
      end
      if (!slot_v && !free_q) begin
        free_idx_q <= chk_idx_i;
      end
      if (take_dump) begin
        pend_entry_q <= ent;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push || cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= res_fin;
    end else if (push) begin
      out_q <= res_push;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/ip_route_table_lpm_top.sv =====
// Top level of the longest-prefix-match IP route table.
//
//   channel  dir  beat carries
//   req_i    in   mode, dest_addr, prefix_mask, gateway_addr, iface_num,
//                 iface_given, route_cost, dump_limit
//   rsp_o    out  status, hop_addr, out_iface, entry_*, dumped_count, last
//
// Every request reads all ENTRIES slots, one per cycle unless a dump beat
// holds the scan, through the single read port of the slot memory. The
// final result beat is registered at commit, after the scan, and the
// next request is taken once the sequencer is idle again; add, delete
// and lookup answer with one beat.
// A dump emits one beat per listed route, the last at commit; each beat waits
// in the result register until taken, and the scan holds while it waits.
// Reset preloads the loopback route in slot 0 and the default route in
// slot 1 at once; no clearing pass follows reset.
// A new request is taken while the previous result beat still waits.
module ip_route_table_lpm_top #(
  parameter int unsigned ENTRIES = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  irt_req_if.sink     req_i,
  irt_rsp_if.source   rsp_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  irt_pkg::cmd_t  cmd;
  irt_pkg::sts_t  sts;
  irt_pkg::res_t  res;
  logic [IW-1:0]  rd_idx;
  logic [IW-1:0]  chk_idx;
  logic           in_ready;
  logic           out_valid;

  // sequencer: one request at a time, scan then commit
  irt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx),
    .chk_idx_o  (chk_idx)
  );

  // table storage, comparators and result register
  irt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (req_i.mode),
    .dest_addr_i    (req_i.dest_addr),
    .prefix_mask_i  (req_i.prefix_mask),
    .gateway_addr_i (req_i.gateway_addr),
    .iface_num_i    (req_i.iface_num),
    .iface_given_i  (req_i.iface_given),
    .route_cost_i   (req_i.route_cost),
    .dump_limit_i   (req_i.dump_limit),
    .cmd_i          (cmd),
    .rd_idx_i       (rd_idx),
    .chk_idx_i      (chk_idx),
    .sts_o          (sts),
    .out_valid_o    (out_valid),
    .out_ready_i    (rsp_o.ready),
    .out_o          (res)
  );

  assign req_i.ready         = in_ready;
  assign rsp_o.valid         = out_valid;
  assign rsp_o.status        = res.status;
  assign rsp_o.hop_addr      = res.hop_addr;
  assign rsp_o.out_iface     = res.out_iface;
  assign rsp_o.entry_dest    = res.entry_dest;
  assign rsp_o.entry_mask    = res.entry_mask;
  assign rsp_o.entry_gateway = res.entry_gateway;
  assign rsp_o.entry_cost    = res.entry_cost;
  assign rsp_o.entry_valid   = res.entry_valid;
  assign rsp_o.dumped_count  = res.dumped_count;
  assign rsp_o.last          = res.last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the longest-prefix-match IP route table.
module testbench;
  import irt_pkg::*;

  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned KEY_COUNT   = 32;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 100;
  // Scan of all slots plus commit, and some slack for the tail
  localparam int unsigned DRAIN_CYCLES = TABLE_SLOTS + 16;

  // One request beat as the sender builds it
  typedef struct {
    mode_e              mode;
    logic [31:0]        dest;
    logic [31:0]        mask;
    logic [31:0]        gw;
    logic [3:0]         iface;
    logic               given;
    logic signed [31:0] cost;
    logic [4:0]         limit;
  } route_req_t;

  // Route table mirror; turns each accepted request into the response
  // beats it must produce and checks them in order.
  class route_scoreboard;
    logic        slot_used  [TABLE_SLOTS];
    logic [31:0] slot_dest  [TABLE_SLOTS];
    logic [31:0] slot_mask  [TABLE_SLOTS];
    logic [31:0] slot_gw    [TABLE_SLOTS];
    logic [3:0]  slot_iface [TABLE_SLOTS];
    logic [31:0] slot_cost  [TABLE_SLOTS];
    res_t        expected_q [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        clear_slot(i);
      end
      slot_used[0] = 1'b1;
      slot_dest[0] = LOOPBACK_NET;
      slot_mask[0] = LOOPBACK_MASK;
      slot_used[1] = 1'b1;
      slot_cost[1] = DEFAULT_COST;
      mismatches   = 0;
    endfunction

    function void clear_slot(int i);
      slot_used[i]  = 1'b0;
      slot_dest[i]  = '0;
      slot_mask[i]  = '0;
      slot_gw[i]    = '0;
      slot_iface[i] = '0;
      slot_cost[i]  = '0;
    endfunction

    function int find_route(logic [31:0] dest, logic [31:0] mask);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_used[i] && slot_dest[i] == dest && slot_mask[i] == mask) return i;
      end
      return -1;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_request(route_req_t r);
      res_t        rs;
      int          hit;
      int unsigned lim;
      int unsigned emitted;
      rs        = '0;
      rs.status = STATUS_OK;
      rs.last   = 1'b1;
      case (r.mode)
        MODE_ADD: begin
          hit = find_route(r.dest, r.mask);
          if (hit < 0) begin
            for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
              if (!slot_used[i]) hit = i;
            end
            if (hit >= 0) begin
              clear_slot(hit);
              slot_used[hit] = 1'b1;
              slot_dest[hit] = r.dest;
              slot_mask[hit] = r.mask;
            end
          end
          if (hit < 0) begin
            rs.status = STATUS_FAIL;
          end else begin
            slot_gw[hit]   = r.gw;
            slot_cost[hit] = r.cost;
            if (r.given) slot_iface[hit] = r.iface;
          end
          expected_q.push_back(rs);
        end
        MODE_DEL: begin
          hit = find_route(r.dest, r.mask);
          if (hit < 0) rs.status = STATUS_FAIL;
          else clear_slot(hit);
          expected_q.push_back(rs);
        end
        MODE_LOOKUP: begin
          hit = -1;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i] && ((r.dest & slot_mask[i]) == (slot_dest[i] & slot_mask[i]))
                && (hit < 0 || slot_mask[i] >= slot_mask[hit])) hit = i;
          end
          if (hit < 0) begin
            rs.status = STATUS_FAIL;
          end else begin
            rs.hop_addr  = (slot_gw[hit] != '0) ? slot_gw[hit] : r.dest;
            rs.out_iface = slot_iface[hit];
          end
          expected_q.push_back(rs);
        end
        default: begin
          lim = 32'(r.limit);
          if (lim > TABLE_SLOTS) lim = TABLE_SLOTS;
          if (lim > MAX_BEATS) lim = MAX_BEATS;
          emitted = 0;
          for (int i = 0; i < TABLE_SLOTS && emitted < lim; i++) begin
            if (slot_used[i]) begin
              emitted++;
              rs.out_iface     = slot_iface[i];
              rs.entry_dest    = slot_dest[i];
              rs.entry_mask    = slot_mask[i];
              rs.entry_gateway = slot_gw[i];
              rs.entry_cost    = slot_cost[i];
              rs.entry_valid   = 1'b1;
              rs.dumped_count  = emitted[4:0];
              rs.last          = 1'b0;
              expected_q.push_back(rs);
            end
          end
          if (emitted == 0) expected_q.push_back(rs);
          else expected_q[expected_q.size() - 1].last = 1'b1;
        end
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) flag($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        flag("response beat with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      check_field("status",        32'(want.status),       32'(got.status));
      check_field("hop_addr",      want.hop_addr,          got.hop_addr);
      check_field("out_iface",     32'(want.out_iface),    32'(got.out_iface));
      check_field("entry_dest",    want.entry_dest,        got.entry_dest);
      check_field("entry_mask",    want.entry_mask,        got.entry_mask);
      check_field("entry_gateway", want.entry_gateway,     got.entry_gateway);
      check_field("entry_cost",    want.entry_cost,        got.entry_cost);
      check_field("entry_valid",   32'(want.entry_valid),  32'(got.entry_valid));
      check_field("dumped_count",  32'(want.dumped_count), 32'(got.dumped_count));
      check_field("last",          32'(want.last),         32'(got.last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  irt_req_if req_bus ();
  irt_rsp_if rsp_bus ();

  ip_route_table_lpm_top #(
    .ENTRIES(TABLE_SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  route_scoreboard route_sb = new();

  // Route keys that the random traffic keeps returning to, so that adds
  // update existing routes and deletes actually hit.
  logic [31:0] key_dest [KEY_COUNT];
  logic [31:0] key_mask [KEY_COUNT];

  // Traffic shaping knobs; written by the stimulus, read by the drivers
  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned items_sent    = 0;

  route_req_t req_seen;
  res_t       rsp_seen;

  // 10-unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Response ready: a pending hold request starts a long stall that this
  // process counts down on its own; otherwise stall at the phase rate.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor both channels on the clock edge. Check the response first so a
  // request taken on the same edge only appends behind older expectations.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        rsp_seen.status        = rsp_bus.status;
        rsp_seen.hop_addr      = rsp_bus.hop_addr;
        rsp_seen.out_iface     = rsp_bus.out_iface;
        rsp_seen.entry_dest    = rsp_bus.entry_dest;
        rsp_seen.entry_mask    = rsp_bus.entry_mask;
        rsp_seen.entry_gateway = rsp_bus.entry_gateway;
        rsp_seen.entry_cost    = rsp_bus.entry_cost;
        rsp_seen.entry_valid   = rsp_bus.entry_valid;
        rsp_seen.dumped_count  = rsp_bus.dumped_count;
        rsp_seen.last          = rsp_bus.last;
        route_sb.check_result(rsp_seen);
      end
      if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
        req_seen.mode  = mode_e'(req_bus.mode);
        req_seen.dest  = req_bus.dest_addr;
        req_seen.mask  = req_bus.prefix_mask;
        req_seen.gw    = req_bus.gateway_addr;
        req_seen.iface = req_bus.iface_num;
        req_seen.given = req_bus.iface_given;
        req_seen.cost  = req_bus.route_cost;
        req_seen.limit = req_bus.dump_limit;
        route_sb.note_request(req_seen);
      end
    end
  end

  // Fields a mode does not use still get random values, so every request
  // bit toggles regardless of the operation mix.
  function automatic route_req_t noise_req(mode_e mode);
    route_req_t r;
    r.mode  = mode;
    r.dest  = $urandom;
    r.mask  = $urandom;
    r.gw    = $urandom;
    r.iface = 4'($urandom_range(0, 15));
    r.given = 1'($urandom_range(0, 1));
    r.cost  = $urandom;
    r.limit = 5'($urandom_range(0, 31));
    return r;
  endfunction

  function automatic route_req_t add_req(logic [31:0] dest, logic [31:0] mask,
                                         logic [31:0] gw, logic [3:0] iface,
                                         logic given, logic [31:0] cost);
    route_req_t r;
    r       = noise_req(MODE_ADD);
    r.dest  = dest;
    r.mask  = mask;
    r.gw    = gw;
    r.iface = iface;
    r.given = given;
    r.cost  = cost;
    return r;
  endfunction

  function automatic route_req_t del_req(logic [31:0] dest, logic [31:0] mask);
    route_req_t r;
    r      = noise_req(MODE_DEL);
    r.dest = dest;
    r.mask = mask;
    return r;
  endfunction

  function automatic route_req_t lookup_req(logic [31:0] addr);
    route_req_t r;
    r      = noise_req(MODE_LOOKUP);
    r.dest = addr;
    return r;
  endfunction

  function automatic route_req_t dump_req(logic [4:0] limit);
    route_req_t r;
    r       = noise_req(MODE_DUMP);
    r.limit = limit;
    return r;
  endfunction

  // Mostly contiguous prefixes, now and then an arbitrary bit pattern
  function automatic logic [31:0] random_mask();
    int unsigned len;
    len = $urandom_range(0, 32);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
  endfunction

  function automatic route_req_t random_pool_req();
    route_req_t  r;
    int unsigned k;
    int unsigned pick;
    k    = $urandom_range(0, KEY_COUNT - 1);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r = add_req(key_dest[k], key_mask[k], ($urandom_range(0, 1) != 0) ? $urandom : 32'h0,
                  4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom);
    end else if (pick < 60) begin
      // a few deletes of routes that were never added
      if ($urandom_range(0, 6) == 0) r = del_req($urandom, random_mask());
      else r = del_req(key_dest[k], key_mask[k]);
    end else if (pick < 90) begin
      case ($urandom_range(0, 9))
        0, 1, 2: r = lookup_req($urandom);
        3:       r = lookup_req(($urandom & 32'hffff_ff00) | LOOPBACK_NET);
        default: r = lookup_req((key_dest[k] & key_mask[k]) | ($urandom & ~key_mask[k]));
      endcase
    end else begin
      r = dump_req(5'($urandom_range(0, 31)));
    end
    return r;
  endfunction

  // Offer one beat and hold it until taken. Valid drops only when an idle
  // gap is inserted, so it never sees two assignments in one step.
  task automatic send_beat(route_req_t r);
    if ($urandom_range(0, 99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    req_bus.valid        <= 1'b1;
    req_bus.mode         <= r.mode;
    req_bus.dest_addr    <= r.dest;
    req_bus.prefix_mask  <= r.mask;
    req_bus.gateway_addr <= r.gw;
    req_bus.iface_num    <= r.iface;
    req_bus.iface_given  <= r.given;
    req_bus.route_cost   <= r.cost;
    req_bus.dump_limit   <= r.limit;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding response beat
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (route_sb.outstanding() != 0);
  endtask

  // Fresh routes until the table overflows, then list it
  task automatic fill_table();
    repeat (TABLE_SLOTS + 2) begin
      send_beat(add_req($urandom, random_mask(), $urandom, 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)), $urandom));
    end
    send_beat(dump_req(5'd16));
  endtask

  // Delete every live route, then probe the empty table
  task automatic empty_table();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (route_sb.slot_used[i]) send_beat(del_req(route_sb.slot_dest[i], route_sb.slot_mask[i]));
    end
    send_beat(dump_req(5'($urandom_range(0, 31))));
    send_beat(lookup_req($urandom));
  endtask

  initial begin
    int unsigned phase_idle  [4];
    int unsigned phase_stall [4];
    int unsigned target;
    int unsigned pick;

    phase_idle  = '{0, 78, 0, 25};
    phase_stall = '{0, 0, 78, 25};

    // Known values on every input before reset releases
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.mode         = MODE_ADD;
    req_bus.dest_addr    = '0;
    req_bus.prefix_mask  = '0;
    req_bus.gateway_addr = '0;
    req_bus.iface_num    = '0;
    req_bus.iface_given  = 1'b0;
    req_bus.route_cost   = '0;
    req_bus.dump_limit   = '0;
    rsp_bus.ready        = 1'b0;

    // Key 0 and 1 are the preloaded routes, so they can be deleted and re-added
    key_dest[0] = LOOPBACK_NET;
    key_mask[0] = LOOPBACK_MASK;
    key_dest[1] = 32'h0;
    key_mask[1] = 32'h0;
    for (int k = 2; k < KEY_COUNT; k++) begin
      key_dest[k] = $urandom;
      key_mask[k] = random_mask();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset contents, every mode, field extremes and corner cases
    send_beat(dump_req(5'd16));                   // the two preloaded routes
    send_beat(lookup_req(32'h0102_037f));         // loopback beats the default
    send_beat(lookup_req(32'hc0a8_0001));         // default route, direct hop
    send_beat(add_req(32'h0000_000a, 32'h0000_00ff, 32'h0100_000a, 4'd3, 1'b1,
                      32'h7fff_ffff));
    // update keeps the interface when none is supplied
    send_beat(add_req(32'h0000_000a, 32'h0000_00ff, 32'h0, 4'd9, 1'b0, 32'h8000_0000));
    send_beat(add_req(32'h0000_010a, 32'h0000_ffff, 32'hffff_ffff, 4'd15, 1'b1,
                      32'hffff_ffff));
    send_beat(add_req(32'hffff_ffff, 32'hffff_ffff, 32'h0, 4'd0, 1'b1, 32'h0));
    // same prefix length as the 0x0a route: the later slot must win ties
    send_beat(add_req(32'h0000_110a, 32'h0000_00ff, 32'h0a0b_0c0d, 4'd5, 1'b1, 32'd7));
    send_beat(lookup_req(32'h5555_000a));
    send_beat(lookup_req(32'hffff_ffff));
    send_beat(lookup_req(32'h0000_010a));
    send_beat(dump_req(5'd0));                    // empty dump
    send_beat(dump_req(5'd31));                   // limit saturates
    send_beat(dump_req(5'd3));
    send_beat(del_req(32'h0000_000a, 32'h0000_00ff));
    send_beat(del_req(32'h0000_000a, 32'h0000_00ff)); // delete miss
    send_beat(del_req(32'h0, 32'h0));             // drop the default route
    send_beat(lookup_req(32'h1234_5678));         // lookup miss
    // new slot without an interface stores zero
    send_beat(add_req(32'h1234_0000, 32'hffff_0000, 32'h0, 4'd7, 1'b0, 32'd100));
    send_beat(del_req(LOOPBACK_NET, LOOPBACK_MASK));
    send_beat(lookup_req(32'h1234_abcd));
    drain_results();

    // Random traffic in four idling phases. The first phase opens with a
    // long response stall so the block backs up and stalls its input.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) hold_requests++;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          fill_table();
        end else if (pick < 18) begin
          empty_table();
        end else begin
          repeat (8) send_beat(random_pool_req());
        end
      end
      // sender pauses until the block has answered everything
      drain_results();
    end

    // Catch any stray beats after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (route_sb.mismatches == 0 && route_sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/irt_pkg.sv
rtl/core/irt_if.sv
rtl/core/irt_ctrl.sv
rtl/core/irt_dp.sv
rtl/core/ip_route_table_lpm_top.sv
tb/testbench.sv
